FILE: rtl/core/blist_pkg.sv
// Shared action codes and controller/datapath handshake types for the bounded list.
package blist_pkg;

    // Field widths of the request and response channels
    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 4;
    localparam int FILL_W   = 4;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_INS_FIRST = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_APPEND    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_DEL_FIRST = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_INS_AT    = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_DUMP      = 3'd4;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic exec;        // apply the accepted request, load its single response
        logic dump_start;  // clear the dump index
        logic dump_load;   // load the response for the cell under the dump index
    } blist_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_busy;    // response register holds a response that is not taken
        logic dump_go;     // pending request is a dump of a non-empty list
        logic dump_last;   // dump index points at the last stored entry
    } blist_stat_t;

endpackage

FILE: rtl/core/blist_req_if.sv
// Request channel interface: valid/ready handshake with action, value and position.
interface blist_req_if;
    logic                               valid;
    logic                               ready;
    logic        [blist_pkg::ACTION_W-1:0] action;
    logic signed [blist_pkg::VALUE_W-1:0]  value;
    logic        [blist_pkg::POS_W-1:0]    position;

    modport source (output valid, action, value, position, input ready);
    modport sink   (input valid, action, value, position, output ready);
endinterface

FILE: rtl/core/blist_rsp_if.sv
// Response channel interface: valid/ready handshake with ok, fill, entry and last.
interface blist_rsp_if;
    logic                                valid;
    logic                                ready;
    logic                                ok;
    logic        [blist_pkg::FILL_W-1:0]  fill;
    logic signed [blist_pkg::VALUE_W-1:0] entry;
    logic                                last;

    modport source (output valid, ok, fill, entry, last, input ready);
    modport sink   (input valid, ok, fill, entry, last, output ready);
endinterface

FILE: rtl/core/bounded_array_list.sv
// Top level of the bounded list: controller plus datapath behind two channels.
//
// Usage:
//   The cmd channel carries one request per handshake: an action (insert first,
//   append, delete first, insert at position, dump), a value and a position.
//   The rsp channel returns responses with ok, fill, entry and last.
//   Every action but a non-empty dump gives one response with last set; its
//   response is registered and valid in the cycle after the request is taken.
//   A dump of n stored entries gives n responses, one per cycle when rsp is
//   not stalled, from the controller's dump state; last marks the final.
//   Throughput: one request per cycle for edit actions when rsp is not
//   stalled; a dump holds cmd ready low while the dump index walks the cells
//   through the single response register.
//   Refused actions (list full, list empty, position past the fill) return ok=0
//   and leave the list unchanged.
//   When rsp stalls, the response register holds and cmd ready drops until the
//   waiting response is taken.
//   Reset empties the list (fill count zero) and drops any pending response;
//   cell contents are not cleared.
module bounded_array_list
#(
    parameter int CAPACITY = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    blist_req_if.sink   cmd,
    blist_rsp_if.source rsp
);
    import blist_pkg::*;

    blist_cmd_t  ctl_cmd;
    blist_stat_t dp_stat;

    blist_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (cmd.valid),
        .req_ready (cmd.ready),
        .stat      (dp_stat),
        .cmd       (ctl_cmd)
    );

    blist_dp
    #(
        .CAPACITY (CAPACITY)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (ctl_cmd),
        .stat      (dp_stat),
        .action    (cmd.action),
        .value     (cmd.value),
        .position  (cmd.position),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .ok        (rsp.ok),
        .fill      (rsp.fill),
        .entry     (rsp.entry),
        .last      (rsp.last)
    );

endmodule

FILE: rtl/core/blist_ctrl.sv
// Controller state machine: request acceptance and dump sequencing.
module blist_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  blist_pkg::blist_stat_t stat,
    output blist_pkg::blist_cmd_t  cmd
);
    import blist_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = req_valid && req_ready;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        req_ready      = 1'b0;
        cmd.exec       = 1'b0;
        cmd.dump_start = 1'b0;
        cmd.dump_load  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = !stat.out_busy;
                if (accept)
                begin
                    if (stat.dump_go)
                    begin
                        cmd.dump_start = 1'b1;
                        state_next     = S_DUMP;
                    end
                    else
                    begin
                        cmd.exec = 1'b1;
                    end
                end
            end
            S_DUMP:
            begin
                if (!stat.out_busy)
                begin
                    cmd.dump_load = 1'b1;
                    if (stat.dump_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // No request is taken while a dump is running
    a_no_accept_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DUMP |-> !req_ready)
        else $error("request accepted during dump");

    // A dump start always leads into the dump state
    a_dump_enter: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dump_start |=> state_reg == S_DUMP)
        else $error("dump start did not enter dump state");

    // The last dump response returns the controller to idle
    a_dump_exit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dump_load && stat.dump_last |=> state_reg == S_IDLE)
        else $error("dump did not end after last entry");

endmodule

FILE: rtl/core/blist_dp.sv
// Datapath: list cells, fill count, dump index and the response register.
module blist_dp
#(
    parameter int CAPACITY = 8
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  blist_pkg::blist_cmd_t                cmd,
    output blist_pkg::blist_stat_t               stat,
    input  logic        [blist_pkg::ACTION_W-1:0] action,
    input  logic signed [blist_pkg::VALUE_W-1:0]  value,
    input  logic        [blist_pkg::POS_W-1:0]    position,
    output logic                                 rsp_valid,
    input  logic                                 rsp_ready,
    output logic                                 ok,
    output logic        [blist_pkg::FILL_W-1:0]  fill,
    output logic signed [blist_pkg::VALUE_W-1:0] entry,
    output logic                                 last
);
    import blist_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    logic signed [VALUE_W-1:0] cells_reg [CAPACITY];
    logic signed [VALUE_W-1:0] cells_next [CAPACITY];
    logic        [CW-1:0]      count_reg;
    logic        [CW-1:0]      count_next;
    logic        [IW-1:0]      idx_reg;
    logic                      valid_reg;
    logic                      ok_reg;
    logic        [FILL_W-1:0]  fill_reg;
    logic signed [VALUE_W-1:0] entry_reg;
    logic                      last_reg;

    logic                      not_full;
    logic                      not_empty;
    logic                      do_ins;
    logic                      do_del;
    logic                      op_ok;
    logic        [CW-1:0]      ins_pos;

    assign not_full  = count_reg < CW'(CAPACITY);
    assign not_empty = count_reg != '0;

    // Decode the request: which edit applies and where an insert lands
    always_comb
    begin
        do_ins  = 1'b0;
        do_del  = 1'b0;
        ins_pos = '0;
        case (action)
            ACT_INS_FIRST:
            begin
                do_ins = not_full;
            end
            ACT_APPEND:
            begin
                do_ins  = not_full;
                ins_pos = count_reg;
            end
            ACT_DEL_FIRST:
            begin
                do_del = not_empty;
            end
            ACT_INS_AT:
            begin
                do_ins  = not_full && (PW'(position) <= PW'(count_reg));
                ins_pos = CW'(position);
            end
            default:
            begin
                do_ins = 1'b0;
            end
        endcase
    end

    assign op_ok = do_ins || do_del;

    // Parallel shift of every cell for insert and delete
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cells_next[i] = cells_reg[i];
            if (do_ins)
            begin
                if (CW'(i) == ins_pos)
                begin
                    cells_next[i] = value;
                end
                else if (i > 0 && CW'(i) > ins_pos && CW'(i) <= count_reg)
                begin
                    cells_next[i] = cells_reg[(i > 0) ? i - 1 : 0];
                end
            end
            else if (do_del)
            begin
                if (i + 1 < CAPACITY && CW'(i + 1) < count_reg)
                begin
                    cells_next[i] = cells_reg[(i + 1 < CAPACITY) ? i + 1 : i];
                end
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_del)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Status to the controller
    assign stat.out_busy  = valid_reg && !rsp_ready;
    assign stat.dump_go   = (action == ACT_DUMP) && not_empty;
    assign stat.dump_last = CW'(idx_reg) == count_reg - 1'b1;

    // List cells: written only by an executed request
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                cells_reg[i] <= cells_next[i];
            end
        end
    end

    // Fill count, dump index and response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                count_reg <= count_next;
            end
            if (cmd.dump_start)
            begin
                idx_reg <= '0;
            end
            else if (cmd.dump_load)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.exec || cmd.dump_load)
            begin
                valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Response payload
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            ok_reg    <= op_ok;
            fill_reg  <= FILL_W'(count_next);
            entry_reg <= '0;
            last_reg  <= 1'b1;
        end
        else if (cmd.dump_load)
        begin
            ok_reg    <= 1'b1;
            fill_reg  <= FILL_W'(count_reg);
            entry_reg <= cells_reg[idx_reg];
            last_reg  <= stat.dump_last;
        end
    end

    assign rsp_valid = valid_reg;
    assign ok        = ok_reg;
    assign fill      = fill_reg;
    assign entry     = entry_reg;
    assign last      = last_reg;

    // Fill count never passes the capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("fill count beyond capacity");

    // Only an executed request changes the fill count
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.exec |=> $stable(count_reg))
        else $error("fill count changed without a request");

    // A new response is never loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec || cmd.dump_load) |-> !(valid_reg && !rsp_ready))
        else $error("response register overwritten");

endmodule
